FILE: rtl/cpt_pkg.sv
// Shared types, widths and region codes for the closest-point-on-triangle core.
// No dependencies.
package cpt_pkg;

    localparam int CRD_W = 32;
    localparam int DIF_W = CRD_W + 1;
    localparam int PRD_W = 2 * DIF_W;
    localparam int DOT_W = PRD_W + 2;
    localparam int VOR_W = 2 * DOT_W + 1;
    localparam int DEN_W = VOR_W + 2;
    localparam int NUM_W = DIF_W + VOR_W + 1;
    localparam int QOT_W = 34;

    localparam logic [2:0] REG_VTX_A   = 3'd0;
    localparam logic [2:0] REG_VTX_B   = 3'd1;
    localparam logic [2:0] REG_EDGE_AB = 3'd2;
    localparam logic [2:0] REG_VTX_C   = 3'd3;
    localparam logic [2:0] REG_EDGE_AC = 3'd4;
    localparam logic [2:0] REG_EDGE_BC = 3'd5;
    localparam logic [2:0] REG_FACE    = 3'd6;

    typedef struct packed {
        logic signed [CRD_W-1:0] ax;
        logic signed [CRD_W-1:0] ay;
        logic signed [CRD_W-1:0] az;
        logic signed [CRD_W-1:0] bx;
        logic signed [CRD_W-1:0] by_coord;
        logic signed [CRD_W-1:0] bz;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic signed [CRD_W-1:0] cz;
        logic signed [CRD_W-1:0] query_x;
        logic signed [CRD_W-1:0] query_y;
        logic signed [CRD_W-1:0] query_z;
    } t_item;

    typedef struct packed {
        logic signed [CRD_W-1:0] near_x;
        logic signed [CRD_W-1:0] near_y;
        logic signed [CRD_W-1:0] near_z;
        logic [2:0]              region;
        logic                    degenerate;
    } t_result;

    typedef struct packed {
        logic [2:0]                  region;
        logic                        degenerate;
        logic                        direct;
        logic [2:0][CRD_W-1:0]       base;
        logic [2:0][NUM_W-1:0]       num;
        logic [DEN_W-1:0]            den;
    } t_job;

endpackage

FILE: rtl/closest_point_on_triangle_core.sv
// Closest point on a 3D triangle to a query point, Q16.16 fixed point, with region code.
// Top level; depends on cpt_pkg, cpt_front, cpt_back and cpt_fifo.
//
// Accepts one query per clock while full is low and returns one result per query in
// order. A query passes the front pipeline (dot products, cross terms, region choice
// and numerators, with 4-stage split multipliers), waits in a small queue, then passes
// the back pipeline, whose 34 stages each resolve one quotient bit of the rounded
// division, and then the output queue. The result queue holds finished results while
// the consumer stalls; input stalls (full) only when both queues fill.
module closest_point_on_triangle_core #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  cpt_pkg::t_item   i_item,
    output cpt_pkg::t_result o_result,
    output logic             empty,
    input  logic             pop
);
    import cpt_pkg::*;

    logic    job_push, job_full, job_pop, job_empty;
    t_job    job_in, job_out;
    logic    res_push, res_full;
    t_result res_in;

    cpt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_job_push (job_push),
        .i_job_full (job_full),
        .o_job      (job_in)
    );

    cpt_fifo #(.W($bits(t_job)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    cpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_job       (job_out),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_res       (res_in)
    );

    cpt_fifo #(.W($bits(t_result)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

FILE: rtl/cpt_mul.sv
// Pipelined signed multiplier built from 34x34 partial products.
// No dependencies.
module cpt_mul #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int CW = 34;
    localparam int PW = AW + BW;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int SW = (NA + NB) * CW;

    logic [AW-1:0]      abs_a;
    logic [BW-1:0]      abs_b;
    logic [NA*CW-1:0]   r_ma;
    logic [NB*CW-1:0]   r_mb;
    logic               r_neg1, r_neg2, r_neg3;
    logic [2*CW-1:0]    r_pp [NA*NB];
    logic [SW-1:0]      c_sum;
    logic [PW-1:0]      r_sum;
    logic [PW-1:0]      r_p;

    assign abs_a = i_a[AW-1] ? (~i_a + 1'b1) : i_a;
    assign abs_b = i_b[BW-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        c_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                c_sum = c_sum + (SW'(r_pp[i*NB+j]) << ((i + j) * CW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= (NA*CW)'(abs_a);
            r_mb   <= (NB*CW)'(abs_b);
            r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= r_ma[i*CW +: CW] * r_mb[j*CW +: CW];
                end
            end
            r_neg2 <= r_neg1;
            r_sum  <= PW'(c_sum);
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? (~r_sum + 1'b1) : r_sum;
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/cpt_fifo.sv
// Small register queue with push/full and pop/empty sides.
// No dependencies.
module cpt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CNTW-1:0] r_cnt;
    logic            do_push, do_pop;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/cpt_front.sv
// Front pipeline: edge vectors, dot products, cross terms, region choice, numerators.
// Depends on cpt_pkg and cpt_mul.
module cpt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  cpt_pkg::t_item i_item,
    output logic           o_job_push,
    input  logic           i_job_full,
    output cpt_pkg::t_job  o_job
);
    import cpt_pkg::*;

    localparam int MUL_LAT = 4;
    localparam int NSTG    = 6 + 2 * MUL_LAT;
    localparam int SEL_L [6] = '{0, 2, 4, 0, 2, 4};
    localparam int SEL_R [6] = '{3, 1, 1, 5, 5, 3};

    typedef struct packed {
        logic [2:0][CRD_W-1:0] a;
        logic [2:0][CRD_W-1:0] b;
        logic [2:0][CRD_W-1:0] c;
        logic [2:0][DIF_W-1:0] ab;
        logic [2:0][DIF_W-1:0] ac;
        logic [2:0][DIF_W-1:0] bc;
        logic [5:0][DOT_W-1:0] d;
    } t_geo;

    typedef struct packed {
        logic [2:0]            region;
        logic                  degenerate;
        logic                  direct;
        logic [2:0][CRD_W-1:0] base;
        logic [DEN_W-1:0]      den;
    } t_cls;

    logic            en;
    logic [NSTG-1:0] r_vld;

    logic [2:0][CRD_W-1:0] in_a, in_b, in_c, in_p;
    logic [2:0][DIF_W-1:0] r1_ap, r1_bp, r1_cp;
    t_geo                  r1_geo, r2_geo, r3_geo, r8_geo;
    logic [PRD_W-1:0]      r2_p [6][3];
    t_geo                  r_gd [MUL_LAT];
    logic [2*DOT_W-1:0]    m_v [6];
    logic [VOR_W-1:0]      r8_va, r8_vb, r8_vc;

    logic signed [DOT_W-1:0] d1, d2, d3, d4, d5, d6;
    logic signed [DOT_W:0]   e, f;
    logic signed [VOR_W-1:0] va, vb, vc;
    t_cls                    c_cls;
    logic signed [DEN_W-1:0] c_den;
    logic [2:0][DIF_W-1:0]   c_x1, c_x2;
    logic signed [VOR_W-1:0] c_y1, c_y2;

    t_cls                    r9_cls;
    logic [2:0][DIF_W-1:0]   r9_x1, r9_x2;
    logic [VOR_W-1:0]        r9_y1, r9_y2;
    t_cls                    r_cd [MUL_LAT];
    logic [DIF_W+VOR_W-1:0]  m_n1 [3];
    logic [DIF_W+VOR_W-1:0]  m_n2 [3];
    t_job                    r14_job;

    function automatic logic [DIF_W-1:0] sub_c(input logic [CRD_W-1:0] x,
                                               input logic [CRD_W-1:0] y);
        return {x[CRD_W-1], x} - {y[CRD_W-1], y};
    endfunction

    assign en     = !r_vld[NSTG-1] || !i_job_full;
    assign o_full = !en;

    assign in_a = {i_item.az, i_item.ay, i_item.ax};
    assign in_b = {i_item.bz, i_item.by_coord, i_item.bx};
    assign in_c = {i_item.cz, i_item.cy, i_item.cx};
    assign in_p = {i_item.query_z, i_item.query_y, i_item.query_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_push};
        end
    end

    // edge vectors, dot products, sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_geo.a <= in_a;
            r1_geo.b <= in_b;
            r1_geo.c <= in_c;
            r1_geo.d <= '0;
            for (int k = 0; k < 3; k++) begin
                r1_geo.ab[k] <= sub_c(in_b[k], in_a[k]);
                r1_geo.ac[k] <= sub_c(in_c[k], in_a[k]);
                r1_geo.bc[k] <= sub_c(in_c[k], in_b[k]);
                r1_ap[k]     <= sub_c(in_p[k], in_a[k]);
                r1_bp[k]     <= sub_c(in_p[k], in_b[k]);
                r1_cp[k]     <= sub_c(in_p[k], in_c[k]);
            end
            r2_geo <= r1_geo;
            for (int k = 0; k < 3; k++) begin
                r2_p[0][k] <= $signed(r1_geo.ab[k]) * $signed(r1_ap[k]);
                r2_p[1][k] <= $signed(r1_geo.ac[k]) * $signed(r1_ap[k]);
                r2_p[2][k] <= $signed(r1_geo.ab[k]) * $signed(r1_bp[k]);
                r2_p[3][k] <= $signed(r1_geo.ac[k]) * $signed(r1_bp[k]);
                r2_p[4][k] <= $signed(r1_geo.ab[k]) * $signed(r1_cp[k]);
                r2_p[5][k] <= $signed(r1_geo.ac[k]) * $signed(r1_cp[k]);
            end
            r3_geo.a  <= r2_geo.a;
            r3_geo.b  <= r2_geo.b;
            r3_geo.c  <= r2_geo.c;
            r3_geo.ab <= r2_geo.ab;
            r3_geo.ac <= r2_geo.ac;
            r3_geo.bc <= r2_geo.bc;
            for (int i = 0; i < 6; i++) begin
                r3_geo.d[i] <= $signed(r2_p[i][0]) + $signed(r2_p[i][1])
                             + $signed(r2_p[i][2]);
            end
        end
    end

    for (genvar g = 0; g < 6; g++) begin : g_vmul
        cpt_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r3_geo.d[SEL_L[g]]),
            .i_b   (r3_geo.d[SEL_R[g]]),
            .o_p   (m_v[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gd[0] <= r3_geo;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_gd[i] <= r_gd[i-1];
            end
            r8_geo <= r_gd[MUL_LAT-1];
            r8_vc  <= $signed(m_v[0]) - $signed(m_v[1]);
            r8_vb  <= $signed(m_v[2]) - $signed(m_v[3]);
            r8_va  <= $signed(m_v[4]) - $signed(m_v[5]);
        end
    end

    assign d1 = r8_geo.d[0];
    assign d2 = r8_geo.d[1];
    assign d3 = r8_geo.d[2];
    assign d4 = r8_geo.d[3];
    assign d5 = r8_geo.d[4];
    assign d6 = r8_geo.d[5];
    assign e  = d4 - d3;
    assign f  = d5 - d6;
    assign va = r8_va;
    assign vb = r8_vb;
    assign vc = r8_vc;

    // region choice, in priority order
    always_comb begin
        c_cls.region = REG_FACE;
        c_cls.direct = 1'b0;
        c_cls.base   = r8_geo.a;
        c_den        = va + vb + vc;
        c_x1         = r8_geo.ab;
        c_x2         = r8_geo.ac;
        c_y1         = vb;
        c_y2         = vc;
        priority if (d1 <= 0 && d2 <= 0) begin
            c_cls.region = REG_VTX_A;
            c_cls.direct = 1'b1;
        end else if (d3 >= 0 && d4 <= d3) begin
            c_cls.region = REG_VTX_B;
            c_cls.direct = 1'b1;
            c_cls.base   = r8_geo.b;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            c_cls.region = REG_EDGE_AB;
            c_den        = d1 - d3;
            c_x2         = '0;
            c_y1         = d1;
            c_y2         = '0;
        end else if (d6 >= 0 && d5 <= d6) begin
            c_cls.region = REG_VTX_C;
            c_cls.direct = 1'b1;
            c_cls.base   = r8_geo.c;
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            c_cls.region = REG_EDGE_AC;
            c_den        = d2 - d6;
            c_x1         = r8_geo.ac;
            c_x2         = '0;
            c_y1         = d2;
            c_y2         = '0;
        end else if (va <= 0 && e >= 0 && f >= 0) begin
            c_cls.region = REG_EDGE_BC;
            c_cls.base   = r8_geo.b;
            c_den        = e + f;
            c_x1         = r8_geo.bc;
            c_x2         = '0;
            c_y1         = e;
            c_y2         = '0;
        end else begin
            c_cls.region = REG_FACE;
        end
        c_cls.degenerate = !c_cls.direct && (c_den == 0);
        if (c_cls.degenerate) begin
            c_cls.direct = 1'b1;
            c_cls.base   = r8_geo.a;
        end
        c_cls.den = c_den;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_cls <= c_cls;
            r9_x1  <= c_x1;
            r9_x2  <= c_x2;
            r9_y1  <= c_y1;
            r9_y2  <= c_y2;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_nmul
        cpt_mul #(.AW(DIF_W), .BW(VOR_W)) u_mul1 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r9_x1[k]),
            .i_b   (r9_y1),
            .o_p   (m_n1[k])
        );
        cpt_mul #(.AW(DIF_W), .BW(VOR_W)) u_mul2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r9_x2[k]),
            .i_b   (r9_y2),
            .o_p   (m_n2[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd[0] <= r9_cls;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_cd[i] <= r_cd[i-1];
            end
            r14_job.region     <= r_cd[MUL_LAT-1].region;
            r14_job.degenerate <= r_cd[MUL_LAT-1].degenerate;
            r14_job.direct     <= r_cd[MUL_LAT-1].direct;
            r14_job.base       <= r_cd[MUL_LAT-1].base;
            r14_job.den        <= r_cd[MUL_LAT-1].den;
            for (int k = 0; k < 3; k++) begin
                r14_job.num[k] <= $signed(m_n1[k]) + $signed(m_n2[k]);
            end
        end
    end

    assign o_job      = r14_job;
    assign o_job_push = r_vld[NSTG-1] && !i_job_full;

endmodule

FILE: rtl/cpt_back.sv
// Back pipeline: rounded division one quotient bit per stage, offset, saturation.
// Depends on cpt_pkg.
module cpt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_empty,
    output logic             o_job_pop,
    input  cpt_pkg::t_job    i_job,
    output logic             o_res_push,
    input  logic             i_res_full,
    output cpt_pkg::t_result o_res
);
    import cpt_pkg::*;

    localparam int RW   = DEN_W + 1 + QOT_W;
    localparam int NDIV = QOT_W + 2;
    localparam int SUMW = QOT_W + 2;

    typedef struct packed {
        logic [2:0][RW-1:0]    rem;
        logic [2:0][QOT_W-1:0] q;
        logic [2:0]            neg;
        logic [2:0]            ovf;
        logic [RW-1:0]         dv;
        logic [2:0]            region;
        logic                  degenerate;
        logic                  direct;
        logic [2:0][CRD_W-1:0] base;
    } t_div;

    logic              en;
    logic [NDIV:0]     r_vld;
    t_div              r_st [NDIV];
    t_div              c_nx [NDIV];
    t_div              c_st0;
    logic [NUM_W-1:0]  un [3];
    logic [DEN_W-1:0]  ud;
    t_result           r_res;
    t_div              fin;
    logic signed [SUMW-1:0]  s_val [3];
    logic [2:0][CRD_W-1:0]   c_near;

    localparam logic signed [SUMW-1:0] SAT_MAX = SUMW'(2147483647);
    localparam logic signed [SUMW-1:0] SAT_MIN = -SUMW'(64'sd2147483648);

    assign en        = !r_vld[NDIV] || !i_res_full;
    assign o_job_pop = en && !i_job_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NDIV-1:0], !i_job_empty};
        end
    end

    // magnitudes; numerator doubled plus divisor rounds half away from zero
    assign ud = i_job.den[DEN_W-1] ? (~i_job.den + 1'b1) : i_job.den;
    always_comb begin
        c_st0.region     = i_job.region;
        c_st0.degenerate = i_job.degenerate;
        c_st0.direct     = i_job.direct;
        c_st0.base       = i_job.base;
        c_st0.dv         = RW'({ud, 1'b0});
        c_st0.q          = '0;
        c_st0.ovf        = '0;
        for (int k = 0; k < 3; k++) begin
            un[k] = i_job.num[k][NUM_W-1] ? (~i_job.num[k] + 1'b1) : i_job.num[k];
            c_st0.neg[k] = i_job.num[k][NUM_W-1] ^ i_job.den[DEN_W-1];
            c_st0.rem[k] = RW'({un[k], 1'b0}) + RW'(ud);
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        c_nx[0] = c_st0;
        c_nx[1] = r_st[0];
        for (int k = 0; k < 3; k++) begin
            c_nx[1].ovf[k] = (r_st[0].rem[k] >= (r_st[0].dv << QOT_W));
        end
        for (int s = 1; s < NDIV - 1; s++) begin
            c_nx[s+1] = r_st[s];
            for (int k = 0; k < 3; k++) begin
                if (r_st[s].rem[k] >= (r_st[s].dv << (QOT_W - s))) begin
                    c_nx[s+1].rem[k]            = r_st[s].rem[k]
                                                - (r_st[s].dv << (QOT_W - s));
                    c_nx[s+1].q[k][QOT_W - s]   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NDIV; s++) begin
                r_st[s] <= c_nx[s];
            end
        end
    end

    assign fin = r_st[NDIV-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_val[k] = $signed({{(SUMW-CRD_W){fin.base[k][CRD_W-1]}}, fin.base[k]})
                     + (fin.neg[k] ? -$signed({2'b00, fin.q[k]})
                                   : $signed({2'b00, fin.q[k]}));
            priority if (fin.direct) begin
                c_near[k] = fin.base[k];
            end else if (fin.ovf[k]) begin
                c_near[k] = fin.neg[k] ? CRD_W'(SAT_MIN) : CRD_W'(SAT_MAX);
            end else if (s_val[k] > SAT_MAX) begin
                c_near[k] = CRD_W'(SAT_MAX);
            end else if (s_val[k] < SAT_MIN) begin
                c_near[k] = CRD_W'(SAT_MIN);
            end else begin
                c_near[k] = s_val[k][CRD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res.near_x     <= c_near[0];
            r_res.near_y     <= c_near[1];
            r_res.near_z     <= c_near[2];
            r_res.region     <= fin.region;
            r_res.degenerate <= fin.degenerate;
        end
    end

    assign o_res      = r_res;
    assign o_res_push = r_vld[NDIV] && !i_res_full;

endmodule

FILE: tb/sv/closest_point_on_triangle_core_tb.sv
// Self-checking testbench for closest_point_on_triangle_core: directed table, then random queries.
// Results are predicted with 256-bit exact arithmetic and compared in order; uses cpt_pkg.
`timescale 1ns / 100ps
module closest_point_on_triangle_core_tb;
    import cpt_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result want;
    } t_row;

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam int N_RANDOM = 1500;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_item   i_item;
    t_result o_result;
    logic    empty;
    logic    pop;

    t_result want_q[$];
    bit      cur_typed;
    t_result cur_want;
    int      n_mismatch;
    bit      hold_req;

    closest_point_on_triangle_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_result(o_result),
        .empty   (empty),
        .pop     (pop)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] place_rounded(wide_t base, wide_t num, wide_t den);
        logic [255:0] un, ud, q;
        wide_t s, lo, hi;
        lo = CMIN;
        hi = CMAX;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (2 * un + ud) / (2 * ud);
        s = ((num < 0) != (den < 0)) ? base - $signed(q) : base + $signed(q);
        if (s < lo) s = lo;
        if (s > hi) s = hi;
        return s[31:0];
    endfunction

    function automatic t_result closest_pt(t_item it);
        wide_t a[3], b[3], c[3], p[3], ab[3], ac[3], ap[3], bp[3], cp[3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den;
        logic [31:0] nr[3];
        t_result r;
        a = '{$signed(it.ax), $signed(it.ay), $signed(it.az)};
        b = '{$signed(it.bx), $signed(it.by_coord), $signed(it.bz)};
        c = '{$signed(it.cx), $signed(it.cy), $signed(it.cz)};
        p = '{$signed(it.query_x), $signed(it.query_y), $signed(it.query_z)};
        for (int k = 0; k < 3; k++) begin
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
        end
        d1 = ab[0] * ap[0] + ab[1] * ap[1] + ab[2] * ap[2];
        d2 = ac[0] * ap[0] + ac[1] * ap[1] + ac[2] * ap[2];
        d3 = ab[0] * bp[0] + ab[1] * bp[1] + ab[2] * bp[2];
        d4 = ac[0] * bp[0] + ac[1] * bp[1] + ac[2] * bp[2];
        d5 = ab[0] * cp[0] + ab[1] * cp[1] + ab[2] * cp[2];
        d6 = ac[0] * cp[0] + ac[1] * cp[1] + ac[2] * cp[2];
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        den = 0;
        r.degenerate = 1'b0;
        if (d1 <= 0 && d2 <= 0) begin
            r.region = REG_VTX_A;
            for (int k = 0; k < 3; k++) nr[k] = a[k][31:0];
        end else if (d3 >= 0 && d4 <= d3) begin
            r.region = REG_VTX_B;
            for (int k = 0; k < 3; k++) nr[k] = b[k][31:0];
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            r.region = REG_EDGE_AB;
            den = d1 - d3;
            if (den != 0)
                for (int k = 0; k < 3; k++) nr[k] = place_rounded(a[k], ab[k] * d1, den);
        end else if (d6 >= 0 && d5 <= d6) begin
            r.region = REG_VTX_C;
            for (int k = 0; k < 3; k++) nr[k] = c[k][31:0];
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            r.region = REG_EDGE_AC;
            den = d2 - d6;
            if (den != 0)
                for (int k = 0; k < 3; k++) nr[k] = place_rounded(a[k], ac[k] * d2, den);
        end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
            r.region = REG_EDGE_BC;
            den = (d4 - d3) + (d5 - d6);
            if (den != 0)
                for (int k = 0; k < 3; k++)
                    nr[k] = place_rounded(b[k], (c[k] - b[k]) * (d4 - d3), den);
        end else begin
            r.region = REG_FACE;
            den = va + vb + vc;
            if (den != 0)
                for (int k = 0; k < 3; k++)
                    nr[k] = place_rounded(a[k], ab[k] * vb + ac[k] * vc, den);
        end
        if (r.region != REG_VTX_A && r.region != REG_VTX_B && r.region != REG_VTX_C
            && den == 0) begin
            r.degenerate = 1'b1;
            for (int k = 0; k < 3; k++) nr[k] = a[k][31:0];
        end
        r.near_x = nr[0];
        r.near_y = nr[1];
        r.near_z = nr[2];
        return r;
    endfunction

    function automatic t_item mk(logic signed [31:0] v[12]);
        t_item it;
        it = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
        return it;
    endfunction

    function automatic t_result res(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, logic [2:0] rg, logic dg);
        t_result r;
        r = {x, y, z, rg, dg};
        return r;
    endfunction

    function automatic logic signed [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return $signed($urandom_range(0, 8)) * ONE - 4 * ONE;
            default: begin
                case ($urandom_range(0, 3))
                    0: return CMIN;
                    1: return CMAX;
                    2: return 0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic t_item rnd_item();
        logic signed [31:0] v[12];
        int mode;
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 8) ? 2 : 3;
        for (int k = 0; k < 12; k++) v[k] = rnd_coord(mode);
        case ($urandom_range(0, 9))
            0: for (int k = 0; k < 3; k++) v[3 + k] = v[k];
            1: for (int k = 0; k < 3; k++) v[6 + k] = v[k];
            2: for (int k = 0; k < 3; k++) v[6 + k] = v[3 + k];
            3: for (int k = 0; k < 3; k++) v[6 + k] = 2 * v[3 + k] - v[k];
            default: ;
        endcase
        return mk(v);
    endfunction

    task automatic send(t_item it, bit typed, t_result want);
        @(negedge i_clk);
        i_item    = it;
        cur_typed = typed;
        cur_want  = want;
        push      = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            push = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            want_q.push_back(cur_typed ? cur_want : closest_pt(i_item));
        if (i_rst_n && pop && !empty) begin
            if (want_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result beat %p", o_result);
            end else begin
                t_result w;
                w = want_q.pop_front();
                if (o_result.near_x !== w.near_x || o_result.near_y !== w.near_y
                    || o_result.near_z !== w.near_z || o_result.region !== w.region
                    || o_result.degenerate !== w.degenerate) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p got %p", w, o_result);
                end
            end
        end
    end

    initial begin
        int mode;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 96)) begin
                @(negedge i_clk);
                if (hold_req) begin
                    pop = 1'b0;
                    repeat (300) @(negedge i_clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0: pop = 1'b1;
                    1: pop = $urandom_range(0, 1);
                    2: pop = ($urandom_range(0, 3) == 0);
                    default: pop = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_row rows[$];
        push       = 1'b0;
        i_item     = '0;
        cur_typed  = 1'b0;
        cur_want   = '0;
        hold_req   = 1'b0;
        n_mismatch = 0;
        i_rst_n    = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero triangle, zero query
        rows.push_back('{mk('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}), 1,
                         res(0, 0, 0, REG_VTX_A, 0)});
        // point triangle
        rows.push_back('{mk('{5, 5, 5, 5, 5, 5, 5, 5, 5, 7, 7, 7}), 1,
                         res(5, 5, 5, REG_VTX_A, 0)});
        // beyond b
        rows.push_back('{mk('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 10 * ONE, 0, 0}), 1,
                         res(ONE, 0, 0, REG_VTX_B, 0)});
        // beyond c
        rows.push_back('{mk('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 10 * ONE, ONE}), 1,
                         res(0, ONE, 0, REG_VTX_C, 0)});
        // a equals b: zero divisor on edge ab
        rows.push_back('{mk('{0, 0, 0, 0, 0, 0, ONE, 0, 0, ONE / 2, 0, 0}), 1,
                         res(0, 0, 0, REG_EDGE_AB, 1)});
        // edges, interior, rounding
        rows.push_back('{mk('{0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 0, ONE, -ONE, 0}), 0, '0});
        rows.push_back('{mk('{0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 0, -ONE, ONE, 0}), 0, '0});
        rows.push_back('{mk('{0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0}),
                         0, '0});
        rows.push_back('{mk('{0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE, 0, ONE, ONE, 5 * ONE}),
                         0, '0});
        rows.push_back('{mk('{0, 0, 0, 3, 0, 0, 0, 7, 0, 1, 1, 1}), 0, '0});
        rows.push_back('{mk('{1, 2, 3, 4, 5, 7, 11, 13, 17, 9, 3, -5}), 0, '0});
        // collinear and extreme coordinates
        rows.push_back('{mk('{0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0, ONE, ONE, 0}), 0, '0});
        rows.push_back('{mk('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN,
                              CMAX, CMIN, CMAX}), 0, '0});
        rows.push_back('{mk('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX,
                              0, 0, 0}), 0, '0});
        rows.push_back('{mk('{CMIN, 0, CMAX, CMAX, CMIN, 0, 0, CMAX, CMIN,
                              CMIN, CMIN, CMIN}), 0, '0});
        rows.push_back('{mk('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}), 0, '0});

        foreach (rows[i]) begin
            send(rows[i].it, rows[i].typed, rows[i].want);
            idle_gap();
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) hold_req = 1'b1;
            if (n == 900) begin
                @(negedge i_clk);
                push = 1'b0;
                wait (want_q.size() == 0);
            end
            send(rnd_item(), 1'b0, '0);
            idle_gap();
        end
        @(negedge i_clk);
        push = 1'b0;
        wait (want_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_mismatch == 0 && want_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
